// ----- sv/tcw_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the text console writer
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLP_W = $clog2(COLUMNS + 1);
    localparam int LINE_W = $clog2(ROWS);

    // field widths
    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int CADDR_W   = 11;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int OCOL_W    = 7;
    localparam int OROW_W    = 5;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // sweep ranges
    localparam int COPY_FIRST      = COLUMNS;
    localparam int COPY_LAST       = (ROWS - 2) * COLUMNS - 1;
    localparam int ROW_BLANK_FIRST = (ROWS - 2) * COLUMNS;
    localparam int ROW_BLANK_LAST  = (ROWS - 1) * COLUMNS - 1;
    localparam int ALL_LAST        = CELLS - 1;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

    // configuration
    localparam logic [ATTR_W-1:0]  COLOR_RESET    = 8'h1F;
    localparam logic               REG_COLOR_IDX  = 1'b0;

    // sweep kinds
    typedef logic [1:0] sweep_kind_t;
    localparam sweep_kind_t SWEEP_ZERO      = 2'd0;
    localparam sweep_kind_t SWEEP_BLANK_ALL = 2'd1;
    localparam sweep_kind_t SWEEP_COPY      = 2'd2;
    localparam sweep_kind_t SWEEP_BLANK_ROW = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic        accept;
        logic        exec_put;
        logic        rd_issue;
        logic        home;
        logic        sweep_load;
        sweep_kind_t load_kind;
        logic        sweep_step;
        sweep_kind_t sweep_kind;
        logic        load_out;
    } tcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              put_scroll;
        logic              sweep_last;
        logic              out_free;
    } tcw_stat_t;

endpackage : tcw_pkg

`default_nettype wire

// ----- sv/text_console_writer_core.sv -----
// top level of the text console writer: stream ports, colour register and core wiring
`default_nettype none

// Text console writer. Keeps an 80x25 store of 16-bit cells (attribute in the
// high byte, character in the low byte) and takes one item per input transfer
// on the slave stream: put a character at the cursor, read one cell, or clear
// the screen. Every item gives exactly one result transfer on the master
// stream carrying the cursor after the item, the cell read (zero otherwise)
// and a scroll flag. Newline goes to column 0 of the next row, backspace steps
// left where it can and blanks that cell, other codes are stored with the
// colour register and move the cursor on, wrapping at the line end. Reaching
// the last row scrolls the body (rows 2..23 up one, row 23 blanked) and leaves
// the header and status rows untouched. All sweeps go through the single write
// port of the cell ram, one cell a cycle. After reset the store is zeroed by a
// pass over all CELLS = 2000 cells during which no item is taken (the colour
// register can be written meanwhile). A finished result waits in the output
// register while the next item is taken in.
module text_console_writer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // slave stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,  // char_code, cell_address, zero pad
    input  wire logic [tcw_pkg::FUNC_W-1:0]        s_tuser,  // func
    // master stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [tcw_pkg::M_TDATA_W-1:0]     m_tdata,  // cursor_col, cursor_row,
                                                             // read_data, scrolled, zero pad
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0]       pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready
);

    tcw_pkg::tcw_cmd_t  cmd;
    tcw_pkg::tcw_stat_t stat;

    logic                        ready;
    logic                        accept;
    logic [tcw_pkg::ATTR_W-1:0]  color_reg;
    logic                        cfg_write;

    logic [tcw_pkg::OCOL_W-1:0]  out_col;
    logic [tcw_pkg::OROW_W-1:0]  out_row;
    logic [tcw_pkg::CELL_W-1:0]  out_data;
    logic                        out_scrolled;

    // colour register, word index taken from the upper address bit
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == tcw_pkg::REG_COLOR_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tcw_pkg::COLOR_RESET;
        end
        else if (cfg_write)
        begin
            color_reg <= pwdata[tcw_pkg::ATTR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == tcw_pkg::REG_COLOR_IDX)
                  ? {{(tcw_pkg::PDATA_W - tcw_pkg::ATTR_W){1'b0}}, color_reg}
                  : '0;

    // input transfer handshake
    assign s_tready = ready;
    assign accept   = s_tvalid && ready;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .stat   (stat),
        .ready  (ready),
        .cmd    (cmd)
    );

    tcw_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .color        (color_reg),
        .in_func      (s_tuser),
        .in_char      (s_tdata[7:0]),
        .in_addr      (s_tdata[18:8]),
        .out_ready    (m_tready),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_col      (out_col),
        .out_row      (out_row),
        .out_data     (out_data),
        .out_scrolled (out_scrolled)
    );

    // result packing, lowest field first
    assign m_tdata = {3'b000, out_scrolled, out_data, out_row, out_col};

`ifndef ASSERT_OFF
    // one item at a time: no second transfer right after an accepted one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken while an item is still in work");

    // the cursor column reported never reaches the line length
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(out_col) < 32'(tcw_pkg::COLUMNS)))
        else $error("cursor column out of range");

    // a scroll always leaves the cursor on the last body row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_scrolled) |-> (out_row == tcw_pkg::OROW_W'(tcw_pkg::ROWS - 2)))
        else $error("scroll reported with cursor off the last body row");

    // only put items report a scroll or read items report data
    a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_scrolled) |-> (out_data == '0))
        else $error("scroll flag together with cell data");
`endif

endmodule : text_console_writer_core

`default_nettype wire

// ----- sv/tcw_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : tcw_ram

`default_nettype wire

// ----- sv/tcw_ctrl.sv -----
// controller state machine: item sequencing, sweeps and result hand-off
`default_nettype none

module tcw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire tcw_pkg::tcw_stat_t stat,
    output logic                    ready,
    output tcw_pkg::tcw_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0]           state_reg, state_next;
    tcw_pkg::sweep_kind_t kind_reg, kind_next;

    // reset starts the zeroing pass over the cell store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            kind_reg  <= tcw_pkg::SWEEP_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.sweep_kind = kind_reg;
        state_next     = state_reg;
        kind_next      = kind_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (stat.func)
                    tcw_pkg::FUNC_PUT:
                    begin
                        cmd.exec_put = 1'b1;
                        if (stat.put_scroll)
                        begin
                            cmd.sweep_load = 1'b1;
                            cmd.load_kind  = tcw_pkg::SWEEP_COPY;
                            kind_next      = tcw_pkg::SWEEP_COPY;
                            state_next     = ST_SWEEP;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_HOLD;
                        end
                    end
                    tcw_pkg::FUNC_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_RD;
                    end
                    tcw_pkg::FUNC_CLEAR:
                    begin
                        cmd.home       = 1'b1;
                        cmd.sweep_load = 1'b1;
                        cmd.load_kind  = tcw_pkg::SWEEP_BLANK_ALL;
                        kind_next      = tcw_pkg::SWEEP_BLANK_ALL;
                        state_next     = ST_SWEEP;
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_HOLD;
                        end
                    end
                endcase
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    if (kind_reg == tcw_pkg::SWEEP_COPY)
                    begin
                        cmd.sweep_load = 1'b1;
                        cmd.load_kind  = tcw_pkg::SWEEP_BLANK_ROW;
                        kind_next      = tcw_pkg::SWEEP_BLANK_ROW;
                    end
                    else if (kind_reg == tcw_pkg::SWEEP_ZERO)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_RD, ST_HOLD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : tcw_ctrl

`default_nettype wire

// ----- sv/tcw_datapath.sv -----
// datapath: cursor, cell store, sweep counter, write pipe and result register
`default_nettype none

module tcw_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tcw_pkg::tcw_cmd_t               cmd,
    input  wire logic [tcw_pkg::ATTR_W-1:0]      color,
    input  wire logic [tcw_pkg::FUNC_W-1:0]      in_func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      in_char,
    input  wire logic [tcw_pkg::CADDR_W-1:0]     in_addr,
    input  wire logic                            out_ready,
    output tcw_pkg::tcw_stat_t                   stat,
    output logic                                 out_valid,
    output logic [tcw_pkg::OCOL_W-1:0]           out_col,
    output logic [tcw_pkg::OROW_W-1:0]           out_row,
    output logic [tcw_pkg::CELL_W-1:0]           out_data,
    output logic                                 out_scrolled
);

    localparam int AW = tcw_pkg::ADDR_W;

    // item registers
    logic [tcw_pkg::FUNC_W-1:0]  func_reg;
    logic [tcw_pkg::CHAR_W-1:0]  char_reg;
    logic [tcw_pkg::CADDR_W-1:0] addr_reg;
    logic                        scr_reg;

    // cursor
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::LINE_W-1:0] line_reg, line_next;

    // sweep counter
    logic [AW-1:0] sweep_reg, sweep_next;

    // write pipe in front of the ram port
    logic                       wr_valid_reg, wr_valid_next;
    logic [AW-1:0]              wr_addr_reg, wr_addr_next;
    logic [tcw_pkg::CELL_W-1:0] wr_data_reg, wr_data_next;
    logic                       wr_copy_reg, wr_copy_next;

    // result register
    logic out_valid_reg;

    logic [tcw_pkg::CELL_W-1:0] blank;
    logic [tcw_pkg::CELL_W-1:0] rdata;
    logic                       re;
    logic [AW-1:0]              raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic                       in_range;

    // put evaluation
    logic [tcw_pkg::COLP_W-1:0] p_col;
    logic [tcw_pkg::LINE_W-1:0] p_line;
    logic [tcw_pkg::COL_W-1:0]  p_wcol;
    logic                       p_we;
    logic [tcw_pkg::CELL_W-1:0] p_wdata;
    logic                       p_scroll;
    logic [AW-1:0]              p_waddr;

    function automatic logic [AW-1:0] sweep_first(input tcw_pkg::sweep_kind_t k);
        logic [AW-1:0] v;
        v = '0;
        case (k)
            tcw_pkg::SWEEP_COPY:      v = AW'(tcw_pkg::COPY_FIRST);
            tcw_pkg::SWEEP_BLANK_ROW: v = AW'(tcw_pkg::ROW_BLANK_FIRST);
            default:                  v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [AW-1:0] sweep_end(input tcw_pkg::sweep_kind_t k);
        logic [AW-1:0] v;
        v = '0;
        case (k)
            tcw_pkg::SWEEP_COPY:      v = AW'(tcw_pkg::COPY_LAST);
            tcw_pkg::SWEEP_BLANK_ROW: v = AW'(tcw_pkg::ROW_BLANK_LAST);
            default:                  v = AW'(tcw_pkg::ALL_LAST);
        endcase
        return v;
    endfunction

    assign blank    = {color, tcw_pkg::CODE_SPACE};
    assign in_range = (32'(addr_reg) < 32'(tcw_pkg::CELLS));

    // cursor motion for one put item
    always_comb
    begin
        p_col   = tcw_pkg::COLP_W'(col_reg);
        p_line  = line_reg;
        p_wcol  = col_reg;
        p_we    = 1'b0;
        p_wdata = {color, char_reg};
        case (char_reg)
            tcw_pkg::CODE_NEWLINE:
            begin
                p_col  = '0;
                p_line = line_reg + 1'b1;
            end
            tcw_pkg::CODE_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    p_wcol = col_reg - 1'b1;
                end
                p_col   = tcw_pkg::COLP_W'(p_wcol);
                p_we    = 1'b1;
                p_wdata = blank;
            end
            default:
            begin
                p_we  = 1'b1;
                p_col = tcw_pkg::COLP_W'(col_reg) + 1'b1;
            end
        endcase
        if (32'(p_col) >= 32'(tcw_pkg::COLUMNS))
        begin
            p_col  = '0;
            p_line = p_line + 1'b1;
        end
        p_scroll = (32'(p_line) >= 32'(tcw_pkg::ROWS - 1));
        if (p_scroll)
        begin
            p_line = tcw_pkg::LINE_W'(tcw_pkg::ROWS - 2);
        end
        p_waddr = AW'(32'(line_reg) * tcw_pkg::COLUMNS + 32'(p_wcol));
    end

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        if (cmd.exec_put)
        begin
            col_next  = tcw_pkg::COL_W'(p_col);
            line_next = p_line;
        end
        else if (cmd.home)
        begin
            col_next  = '0;
            line_next = '0;
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_load)
        begin
            sweep_next = sweep_first(cmd.load_kind);
        end
        else if (cmd.sweep_step)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_comb
    begin
        wr_valid_next = 1'b0;
        wr_addr_next  = wr_addr_reg;
        wr_data_next  = wr_data_reg;
        wr_copy_next  = 1'b0;
        if (cmd.sweep_step)
        begin
            wr_valid_next = 1'b1;
            wr_addr_next  = sweep_reg;
            wr_copy_next  = (cmd.sweep_kind == tcw_pkg::SWEEP_COPY);
            wr_data_next  = (cmd.sweep_kind == tcw_pkg::SWEEP_ZERO) ? '0 : blank;
        end
        else if (cmd.exec_put && p_we)
        begin
            wr_valid_next = 1'b1;
            wr_addr_next  = p_waddr;
            wr_data_next  = p_wdata;
        end
    end

    // copy reads one row ahead of the write that follows it
    assign re        = cmd.rd_issue || (cmd.sweep_step && (cmd.sweep_kind == tcw_pkg::SWEEP_COPY));
    assign raddr     = cmd.rd_issue ? AW'(addr_reg) : (sweep_reg + AW'(tcw_pkg::COLUMNS));
    assign ram_wdata = wr_copy_reg ? rdata : wr_data_reg;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (wr_valid_reg),
        .waddr (wr_addr_reg),
        .wdata (ram_wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            line_reg      <= '0;
            sweep_reg     <= '0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            line_reg     <= line_next;
            sweep_reg    <= sweep_next;
            wr_valid_reg <= wr_valid_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= wr_data_next;
        wr_copy_reg <= wr_copy_next;
        if (cmd.accept)
        begin
            func_reg <= in_func;
            char_reg <= in_char;
            addr_reg <= in_addr;
            scr_reg  <= 1'b0;
        end
        else if (cmd.exec_put)
        begin
            scr_reg <= p_scroll;
        end
        if (cmd.load_out)
        begin
            out_col      <= tcw_pkg::OCOL_W'(col_next);
            out_row      <= tcw_pkg::OROW_W'(line_next);
            out_data     <= ((func_reg == tcw_pkg::FUNC_READ) && in_range) ? rdata : '0;
            out_scrolled <= cmd.exec_put ? p_scroll : scr_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign stat.func       = func_reg;
    assign stat.put_scroll = p_scroll;
    assign stat.sweep_last = (sweep_reg == sweep_end(cmd.sweep_kind));
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule : tcw_datapath

`default_nettype wire
